// ===== design/tap_tempo_estimator_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Tap tempo estimator assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TAP_TEMPO_ESTIMATOR_UNIT_ASSERT_SVH
`define TAP_TEMPO_ESTIMATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tte_pkg.sv =====
// ---------------------------------------------------------------------------
// Tap tempo estimator package
// Sizes, reset values, controller states and control/status words.
// ---------------------------------------------------------------------------
package tte_pkg;

    // history depth and derived widths
    localparam int TAP_DEPTH   = 8;
    localparam int IDX_W       = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TAP_DEPTH + 1);
    localparam int SUM_W       = IDX_W + 1;

    // field widths
    localparam int TIME_W      = 32;
    localparam int TIMEOUT_W   = 16;
    localparam int TAP_COUNT_W = 4;

    // serial divider
    localparam int DIV_STEPS   = TIME_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1999;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_ctrl_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic decide;
        logic div_start;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } t_dp_status;

endpackage

// ===== design/tap_tempo_estimator_unit.sv =====
// ---------------------------------------------------------------------------
// Tap tempo estimator unit
// Average interval of recent taps, with timeout restart of the history.
// ---------------------------------------------------------------------------
// channel   direction  handshake           payload
// tap       in         i_valid / o_stall   i_now_ms
// result    out        o_valid / i_stall   o_tempo_ms, o_tap_count, o_restarted
// timeout   in         i_timeout_we        i_timeout_ms
//
// After a tap is accepted, its result is loaded through history update,
// oldest-tap read from the ring memory, divider load, 32 serial divide steps,
// done detect and result load. The next tap is taken back in the idle state.
// A new tap is accepted while a finished result waits in the output register.
// Reset is synchronous active low: history empty, timeout 1999 ms.
// A stalled result holds the sequencer in its last step until taken.
// ---------------------------------------------------------------------------
module tap_tempo_estimator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [tte_pkg::TIME_W-1:0]        i_now_ms,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [tte_pkg::TIME_W-1:0]        o_tempo_ms,
    output logic [tte_pkg::TAP_COUNT_W-1:0]   o_tap_count,
    output logic                              o_restarted,
    input  logic                              i_timeout_we,
    input  logic [tte_pkg::TIMEOUT_W-1:0]     i_timeout_ms
);
    import tte_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencer
    tte_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    // history and arithmetic
    tte_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_timeout_we (i_timeout_we),
        .i_timeout_ms (i_timeout_ms),
        .i_now_ms     (i_now_ms),
        .o_tempo_ms   (o_tempo_ms),
        .o_tap_count  (o_tap_count),
        .o_restarted  (o_restarted)
    );

endmodule

// ===== design/tte_div.sv =====
// ---------------------------------------------------------------------------
// Tap tempo serial divider
// Restoring divider, one quotient bit per cycle, narrow divisor.
// ---------------------------------------------------------------------------
module tte_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tte_pkg::TIME_W-1:0]  i_dividend,
    input  logic [tte_pkg::CNT_W-1:0]   i_divisor,
    output logic [tte_pkg::TIME_W-1:0]  o_quotient,
    output logic                        o_done
);
    import tte_pkg::*;

    logic [TIME_W-1:0] r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [CNT_W:0]    w_trial;
    logic              w_fit;
    logic [CNT_W:0]    w_diff;

    // one restoring step
    assign w_trial = {r_rem, r_quo[TIME_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[TIME_W-2:0], w_fit};
            r_rem <= w_fit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ===== design/tte_datapath.sv =====
// ---------------------------------------------------------------------------
// Tap tempo datapath
// Tap history ring, timeout check, span divide and result register.
// ---------------------------------------------------------------------------
module tte_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tte_pkg::t_dp_cmd                  i_cmd,
    output tte_pkg::t_dp_status               o_status,
    input  logic                              i_timeout_we,
    input  logic [tte_pkg::TIMEOUT_W-1:0]     i_timeout_ms,
    input  logic [tte_pkg::TIME_W-1:0]        i_now_ms,
    output logic [tte_pkg::TIME_W-1:0]        o_tempo_ms,
    output logic [tte_pkg::TAP_COUNT_W-1:0]   o_tap_count,
    output logic                              o_restarted
);
    import tte_pkg::*;

    logic [TIME_W-1:0]    r_mem [TAP_DEPTH];
    logic [TIME_W-1:0]    r_rd_data;
    logic [IDX_W-1:0]     r_head;
    logic [CNT_W-1:0]     r_count;
    logic [TIMEOUT_W-1:0] r_timeout;
    logic [TIME_W-1:0]    r_now;
    logic [TIME_W-1:0]    r_newest;
    logic                 r_restart;
    logic [TIME_W-1:0]    r_out_tempo;
    logic [CNT_W-1:0]     r_out_count;
    logic                 r_out_restart;

    logic [TIME_W-1:0]    w_gap;
    logic                 w_restart;
    logic                 w_full;
    logic [SUM_W-1:0]     w_tail_sum;
    logic [IDX_W-1:0]     w_tail;
    logic [SUM_W-1:0]     w_head_sum;
    logic [IDX_W-1:0]     w_head_inc;
    logic [IDX_W-1:0]     w_wr_addr;
    logic [IDX_W-1:0]     n_head;
    logic [CNT_W-1:0]     n_count;
    logic [TIME_W-1:0]    w_quo;
    logic                 w_div_done;

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_timeout_we) begin
            r_timeout <= i_timeout_ms;
        end
    end

    // restart decision, modular gap
    assign w_gap     = r_now - r_newest;
    assign w_restart = (r_count == '0) || (w_gap > {{(TIME_W-TIMEOUT_W){1'b0}}, r_timeout});
    assign w_full    = (r_count == CNT_W'(TAP_DEPTH));

    // ring positions
    assign w_tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_tail     = (w_tail_sum >= SUM_W'(TAP_DEPTH)) ?
                        IDX_W'(w_tail_sum - SUM_W'(TAP_DEPTH)) : w_tail_sum[IDX_W-1:0];
    assign w_head_sum = SUM_W'(r_head) + SUM_W'(1);
    assign w_head_inc = (w_head_sum >= SUM_W'(TAP_DEPTH)) ? '0 : w_head_sum[IDX_W-1:0];

    always_comb begin
        if (w_restart) begin
            w_wr_addr = '0;
            n_head    = '0;
            n_count   = CNT_W'(1);
        end else if (w_full) begin
            w_wr_addr = r_head;
            n_head    = w_head_inc;
            n_count   = r_count;
        end else begin
            w_wr_addr = w_tail;
            n_head    = r_head;
            n_count   = r_count + 1'b1;
        end
    end

    // history control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.decide) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // captured word and newest tap
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_now <= i_now_ms;
        end
        if (i_cmd.decide) begin
            r_newest  <= r_now;
            r_restart <= w_restart;
        end
    end

    // tap memory, oldest entry read at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_mem[w_wr_addr] <= r_now;
        end
        r_rd_data <= r_mem[r_head];
    end

    // span over count minus one
    tte_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_newest - r_rd_data),
        .i_divisor  (r_count - 1'b1),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    assign o_status.div_done = w_div_done;

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_tempo   <= (r_count >= CNT_W'(2)) ? w_quo : '0;
            r_out_count   <= r_count;
            r_out_restart <= r_restart;
        end
    end

    assign o_tempo_ms  = r_out_tempo;
    assign o_tap_count = TAP_COUNT_W'(r_out_count);
    assign o_restarted = r_out_restart;

    `include "tap_tempo_estimator_unit_assert.svh"

    `TTE_ASSERT_IMP(a_count_range, 1'b1, r_count <= CNT_W'(TAP_DEPTH), "tap count above depth")
    `TTE_ASSERT_NXT(a_count_held, i_cmd.decide, r_count != '0, "empty history after tap")
    `TTE_ASSERT_NXT(a_restart_one, i_cmd.decide && w_restart, (r_count == CNT_W'(1)) && (r_head == '0), "restart did not reset history")

endmodule

// ===== design/tte_ctrl.sv =====
// ---------------------------------------------------------------------------
// Tap tempo controller
// Sequences capture, history update, oldest read, divide and result load.
// ---------------------------------------------------------------------------
module tte_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  logic                  i_stall,
    output tte_pkg::t_dp_cmd      o_cmd,
    input  tte_pkg::t_dp_status   i_status
);
    import tte_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_out_valid;
    logic        n_out_valid;
    logic        w_slot_free;

    assign w_slot_free = !r_out_valid || !i_stall;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_READ;
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result valid
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    `include "tap_tempo_estimator_unit_assert.svh"

    `TTE_ASSERT_IMP(a_load_free, o_cmd.out_load, !r_out_valid || !i_stall, "result overwritten while held")
    `TTE_ASSERT_NXT(a_accept_seq, i_valid && !o_stall, r_state == S_DECIDE, "accepted word not decided")
    `TTE_ASSERT_NXT(a_div_done, (r_state == S_DIV) && i_status.div_done, r_state == S_DONE, "divide done missed")

endmodule

// ===== sim/tb_tap_tempo_estimator_unit.sv =====
// ---------------------------------------------------------------------------
// Tap tempo estimator unit testbench
// Drives tap words through the valid/stall channel and checks each result word
// against an in-bench prediction of the tap history, restart and average
// interval. It sweeps several timeout settings and three idling profiles.
// ---------------------------------------------------------------------------
module tb_tap_tempo_estimator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import tte_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int MAX_REPORTS    = 10;

    // one result word as the block reports it
    typedef struct packed {
        logic [TIME_W-1:0]      tempo;
        logic [TAP_COUNT_W-1:0] count;
        logic                   restarted;
    } t_tempo_result;

    // clock, reset and block inputs, all known from time zero
    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_valid      = 1'b0;
    logic [TIME_W-1:0]      i_now_ms     = '0;
    logic                   i_stall      = 1'b0;
    logic                   i_timeout_we = 1'b0;
    logic [TIMEOUT_W-1:0]   i_timeout_ms = '0;

    logic                   o_stall;
    logic                   o_valid;
    logic [TIME_W-1:0]      o_tempo_ms;
    logic [TAP_COUNT_W-1:0] o_tap_count;
    logic                   o_restarted;

    // stimulus and prediction state
    logic [TIME_W-1:0]      pending_taps [$];
    t_tempo_result          expected_results [$];
    logic [TIME_W-1:0]      hist_times [TAP_DEPTH];
    int                     hist_count;
    logic [TIMEOUT_W-1:0]   model_timeout;
    logic [TIMEOUT_W-1:0]   cfg_timeout = TIMEOUT_RESET;
    logic [TIME_W-1:0]      tap_stamp;
    t_tempo_result          mon_want;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int taps_accepted  = 0;
    int results_seen   = 0;
    int restarts_seen  = 0;
    int full_seen      = 0;
    int settings_used  = 1;

    logic [TIME_W-1:0] directed_taps [22] = '{
        32'h0000_0000,  // empty history
        32'd1999,       // gap equal to timeout, held
        32'd3999,       // gap one above timeout, restart
        32'd4000, 32'd5999, 32'd5999, 32'd6499, 32'd6506,
        32'd7740, 32'd8740, 32'd8743,  // history now full
        32'd9000, 32'd9001,            // oldest shifted out
        32'hFFFF_FC00,  // far jump, restart
        32'hFFFF_FFFF,  // top of range
        32'h0000_0100,  // wraps through zero
        32'h0000_08CF,  // gap equal to timeout after the wrap
        32'h0000_0000,  // backward step reads as a huge gap
        32'h7FFF_FFFF, 32'h8000_0000,
        32'hAAAA_AAAA, 32'h5555_5555
    };

    tap_tempo_estimator_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_now_ms     (i_now_ms),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tempo_ms   (o_tempo_ms),
        .o_tap_count  (o_tap_count),
        .o_restarted  (o_restarted),
        .i_timeout_we (i_timeout_we),
        .i_timeout_ms (i_timeout_ms)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // update the tap history for one tap and return the word it should produce
    function automatic t_tempo_result predict_tap(input logic [TIME_W-1:0] now);
        t_tempo_result     r;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] span;
        r.restarted = 1'b0;
        r.tempo     = '0;
        if (hist_count == 0) begin
            hist_times[0] = now;
            hist_count    = 1;
            r.restarted   = 1'b1;
        end else begin
            gap = now - hist_times[hist_count-1];
            if (gap > TIME_W'(model_timeout)) begin
                hist_times[0] = now;
                hist_count    = 1;
                r.restarted   = 1'b1;
            end else if (hist_count == TAP_DEPTH) begin
                for (int i = 0; i < TAP_DEPTH - 1; i++) hist_times[i] = hist_times[i+1];
                hist_times[TAP_DEPTH-1] = now;
            end else begin
                hist_times[hist_count] = now;
                hist_count++;
            end
        end
        if (hist_count >= 2) begin
            span    = hist_times[hist_count-1] - hist_times[0];
            r.tempo = span / TIME_W'(hist_count - 1);
        end
        r.count = TAP_COUNT_W'(hist_count);
        return r;
    endfunction

    // driver: track register writes, predict accepted taps, present the next word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hist_count    = 0;
            model_timeout = TIMEOUT_RESET;
            i_valid      <= 1'b0;
        end else begin
            if (i_timeout_we) model_timeout = i_timeout_ms;
            if (i_valid && !o_stall) begin
                expected_results.push_back(predict_tap(i_now_ms));
                taps_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_taps.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid  <= 1'b1;
                    i_now_ms <= pending_taps.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input t_tempo_result want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s: exp tempo=%0d count=%0d restart=%0d, %s=%0d count=%0d restart=%0d",
                     $realtime, what, want.tempo, want.count, want.restarted,
                     "got tempo", o_tempo_ms, o_tap_count, o_restarted);
    endtask

    // monitor: check each taken result word, then pick the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (o_restarted === 1'b1) restarts_seen++;
                if (o_tap_count === TAP_COUNT_W'(TAP_DEPTH)) full_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", '0);
                end else begin
                    mon_want = expected_results.pop_front();
                    if (o_tempo_ms !== mon_want.tempo)
                        report_mismatch("tempo mismatch", mon_want);
                    else if (o_tap_count !== mon_want.count)
                        report_mismatch("count mismatch", mon_want);
                    else if (o_restarted !== mon_want.restarted)
                        report_mismatch("restart mismatch", mon_want);
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // wait until every queued tap went in and every result came out;
    // sampled mid-cycle so the edge updates have settled
    task automatic drain();
        while (pending_taps.size() != 0 || i_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        drain();
        repeat (4) @(posedge i_clk);
        i_timeout_we <= 1'b1;
        i_timeout_ms <= value;
        @(posedge i_clk);
        i_timeout_we <= 1'b0;
        cfg_timeout = value;
        settings_used++;
    endtask

    // mostly runs of taps within the timeout, with some restarts and noise
    task automatic queue_random_taps(input int n);
        int                pick;
        logic [TIME_W-1:0] gap;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      gap = $urandom_range(0, cfg_timeout);
            else if (pick < 78) gap = TIME_W'(cfg_timeout);
            else if (pick < 86) gap = TIME_W'(cfg_timeout) + 1;
            else if (pick < 93) gap = $urandom();
            else                gap = '0;
            tap_stamp = tap_stamp + gap;
            pending_taps.push_back(tap_stamp);
        end
    endtask

    task automatic run_phase(input logic [TIMEOUT_W-1:0] value, input int n,
                             input int send_pct, input int recv_pct);
        write_timeout(value);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        queue_random_taps(n);
    endtask

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("watchdog expired after %0d cycles", cycle_count);
        $display("Regression FAIL");
        $finish;
    end

    // sequence of phases
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed taps at the reset timeout
        send_idle_pct = 12;
        recv_idle_pct = 59;
        foreach (directed_taps[k]) pending_taps.push_back(directed_taps[k]);
        tap_stamp = directed_taps[21];

        run_phase(16'd0,       200, 12, 59);
        run_phase(16'hFFFF,    350, 59, 12);
        run_phase(TIMEOUT_W'($urandom_range(2, 65534)), 350, 59, 12);
        run_phase(TIMEOUT_RESET, 350, 0, 0);
        run_phase(16'd1,       400, 0, 0);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d taps, %0d results over %0d timeout settings",
                 taps_accepted, results_seen, settings_used);
        $display("history restarts %0d, full-history results %0d, mismatches %0d",
                 restarts_seen, full_seen, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== tap_tempo_estimator_unit.f =====
+incdir+design
design/tte_pkg.sv
design/tte_div.sv
design/tte_datapath.sv
design/tte_ctrl.sv
design/tap_tempo_estimator_unit.sv
sim/tb_tap_tempo_estimator_unit.sv
